// File: design/hlbh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlbh_pkg
// Shared types and constants of the Hough line bin histogram.
// ----------------------------------------------------------------------------
package hlbh_pkg;

   // coordinate and bin widths
   localparam int COORD_BITS = 10;
   localparam int CC_W       = COORD_BITS + 1;
   localparam int BIN_W      = 8;
   localparam int OUT_BIN_W  = 6;
   localparam int COUNT_W    = 16;
   localparam int TOTAL_W    = 20;

   // datapath widths
   localparam int CX_W    = 30;
   localparam int Z_W     = 20;
   localparam int TH_W    = 21;
   localparam int THU_W   = 18;
   localparam int DPROD_W = 45;
   localparam int DIST_W  = 28;
   localparam int RN_W    = 23;
   localparam int MAG_W   = 22;
   localparam int DEN_W   = 40;
   localparam int NUM_W   = 56;
   localparam int Q_W     = 17;
   localparam int STEP_W  = 5;
   localparam int U_W     = 17;
   localparam int APROD_W = 49;
   localparam int AREM_W  = 34;

   // fixed point constants, 16 fractional bits
   localparam int CORDIC_STEPS = 16;
   localparam int FRAC_BITS    = 16;
   localparam int PI_Q16       = 205887;
   localparam int HALF_PI_Q16  = 102944;
   localparam int INV_GAIN_Q16 = 39797;
   localparam int Q_ONE        = 65536;
   localparam int HALF_SCALE   = 32768;
   localparam int FRAC_MAX     = 65535;
   localparam int COUNT_MAX    = 65535;
   localparam int TOTAL_MAX    = 1048575;
   localparam int RADIUS_STEPS = 15;
   localparam int SHARE_STEPS  = 17;
   // floor(2^48 / pi_q16), angle scale by reciprocal
   localparam int ANGLE_RECIP  = 1367133314;

   // configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 11;
   localparam int MR_W        = 11;
   localparam int NBINS_W     = 7;

   typedef enum logic [1:0] {
      OP_ADD   = 2'd0,
      OP_READ  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CENTRE_COLUMN    = 3'd0,
      CSR_CENTRE_ROW       = 3'd1,
      CSR_MAX_RADIUS       = 3'd2,
      CSR_ANGLE_BINS_USED  = 3'd3,
      CSR_RADIUS_BINS_USED = 3'd4
   } csr_index_type;

   typedef enum logic [4:0] {
      B_INIT,
      B_IDLE,
      B_CORDIC,
      B_MULT,
      B_FOLD,
      B_DEN,
      B_ANG_GO,
      B_ANG_WAIT,
      B_RAD_GO,
      B_RAD_WAIT,
      B_BIN,
      B_ADDR,
      B_LOOK,
      B_UPD,
      B_FRAC_GO,
      B_FRAC_WAIT,
      B_CLEAR
   } back_state_type;

   typedef struct packed {
      logic [1:0]            operation;
      logic [COORD_BITS-1:0] first_x;
      logic [COORD_BITS-1:0] first_y;
      logic [COORD_BITS-1:0] second_x;
      logic [COORD_BITS-1:0] second_y;
      logic [OUT_BIN_W-1:0]  read_angle_bin;
      logic [OUT_BIN_W-1:0]  read_radius_bin;
   } req_type;

   typedef struct packed {
      logic                 accepted;
      logic [OUT_BIN_W-1:0] angle_bin;
      logic [OUT_BIN_W-1:0] radius_bin;
      logic [COUNT_W-1:0]   bin_count;
      logic [COUNT_W-1:0]   bin_fraction;
      logic [TOTAL_W-1:0]   total_segments;
   } rsp_type;

   // classified item handed from front to back
   typedef struct packed {
      op_type                 op;
      logic                   zero_len;
      logic signed [CC_W-1:0] x1c;
      logic signed [CC_W-1:0] y1c;
      logic [COORD_BITS-1:0]  dx;
      logic signed [CC_W-1:0] dy;
      logic [OUT_BIN_W-1:0]   rd_abin;
      logic [OUT_BIN_W-1:0]   rd_rbin;
   } fe_item_type;

   // cordic step angles, atan(2^-i) * 2^16 rounded to nearest, but for i = 1, which is truncated
   function automatic logic signed [Z_W-1:0] cordic_angle(input logic [3:0] i);
      logic signed [Z_W-1:0] a;
      unique case (i)
         4'd0:    a = Z_W'(51472);
         4'd1:    a = Z_W'(30385);
         4'd2:    a = Z_W'(16055);
         4'd3:    a = Z_W'(8150);
         4'd4:    a = Z_W'(4091);
         4'd5:    a = Z_W'(2047);
         4'd6:    a = Z_W'(1024);
         4'd7:    a = Z_W'(512);
         4'd8:    a = Z_W'(256);
         4'd9:    a = Z_W'(128);
         4'd10:   a = Z_W'(64);
         4'd11:   a = Z_W'(32);
         4'd12:   a = Z_W'(16);
         4'd13:   a = Z_W'(8);
         4'd14:   a = Z_W'(4);
         default: a = Z_W'(2);
      endcase
      return a;
   endfunction

endpackage

// File: design/hlbh_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlbh_front
// Accepts commands, orders the endpoints and moves them to the centred frame.
// ----------------------------------------------------------------------------
module hlbh_front import hlbh_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  req_type               req_data,
   input  logic [COORD_BITS-1:0] centre_column,
   input  logic [COORD_BITS-1:0] centre_row,
   input  logic                  hold,
   input  logic                  q_full,
   output logic                  busy,
   output logic                  push,
   output fe_item_type           push_item
);

   logic        valid_ff, valid_in;
   fe_item_type item_ff, item_in;
   logic        accept, swap;
   logic [COORD_BITS-1:0] ax, ay, bx, by;

   assign busy   = hold || (valid_ff && q_full);
   assign accept = start && !busy;
   assign push   = valid_ff && !q_full;
   assign push_item = item_ff;

   // order endpoints: smaller column first, then smaller row
   assign swap = (req_data.second_x < req_data.first_x) ||
                 ((req_data.second_x == req_data.first_x) &&
                  (req_data.second_y < req_data.first_y));
   assign ax = swap ? req_data.second_x : req_data.first_x;
   assign ay = swap ? req_data.second_y : req_data.first_y;
   assign bx = swap ? req_data.first_x  : req_data.second_x;
   assign by = swap ? req_data.first_y  : req_data.second_y;

   // classify and centre
   always_comb begin
      item_in.op       = op_type'(req_data.operation);
      item_in.zero_len = (ax == bx) && (ay == by);
      item_in.x1c      = $signed({1'b0, ax}) - $signed({1'b0, centre_column});
      item_in.y1c      = $signed({1'b0, centre_row}) - $signed({1'b0, ay});
      item_in.dx       = bx - ax;
      item_in.dy       = $signed({1'b0, ay}) - $signed({1'b0, by});
      item_in.rd_abin  = req_data.read_angle_bin;
      item_in.rd_rbin  = req_data.read_radius_bin;
      if (accept) begin
         valid_in = 1'b1;
      end else if (push) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

endmodule

// File: design/hlbh_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlbh_queue
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
module hlbh_queue import hlbh_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  fe_item_type push_item,
   input  logic        pop,
   output fe_item_type pop_item,
   output logic        full,
   output logic        not_empty
);

   fe_item_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_item  = entry_ff[rd_ptr_ff];

   // pointer and fill update
   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: design/hlbh_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlbh_div
// Restoring divider, one quotient bit per cycle, shared by the back.
// ----------------------------------------------------------------------------
module hlbh_div import hlbh_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [NUM_W-1:0]  num,
   input  logic [DEN_W-1:0]  den,
   input  logic [STEP_W-1:0] steps,
   output logic              done,
   output logic [Q_W-1:0]    quot
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [DEN_W-1:0]  den_ff;
   logic [Q_W-1:0]    num_ff;
   logic [Q_W-1:0]    quot_ff, quot_in;
   logic [STEP_W-1:0] idx_ff, idx_in;
   logic [DEN_W:0]    trial;
   logic              qbit;

   assign done = done_ff;
   assign quot = quot_ff;

   // one trial subtraction per cycle
   always_comb begin
      trial = {rem_ff, num_ff[idx_ff]};
      qbit  = (trial >= {1'b0, den_ff});
      if (start) begin
         rem_in  = DEN_W'(num >> steps);
         quot_in = '0;
         idx_in  = steps - STEP_W'(1);
      end else if (busy_ff) begin
         rem_in  = qbit ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
         quot_in = {quot_ff[Q_W-2:0], qbit};
         idx_in  = idx_ff - STEP_W'(1);
      end else begin
         rem_in  = rem_ff;
         quot_in = quot_ff;
         idx_in  = idx_ff;
      end
      busy_in = start || (busy_ff && (idx_ff != '0));
      done_in = busy_ff && (idx_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      idx_ff  <= idx_in;
      if (start) begin
         num_ff <= num[Q_W-1:0];
         den_ff <= den;
      end
   end

   // partial remainder stays below the divisor
   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (rem_ff < den_ff))
      else $error("divider remainder not below divisor");

endmodule

// File: design/hlbh_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlbh_back
// Runs each command: cordic, binning, vote store update or read, share of total, store clear.
// ----------------------------------------------------------------------------
module hlbh_back import hlbh_pkg::*; #(
   parameter int MAX_ANGLE_BINS  = 64,
   parameter int MAX_RADIUS_BINS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [MR_W-1:0]    max_radius,
   input  logic [NBINS_W-1:0] angle_bins_used,
   input  logic [NBINS_W-1:0] radius_bins_used,
   input  logic               q_not_empty,
   input  fe_item_type        q_item,
   output logic               q_pop,
   output logic               sweep_busy,
   output logic               rsp_valid,
   output rsp_type            rsp_data
);

   localparam int DEPTH  = MAX_ANGLE_BINS * MAX_RADIUS_BINS;
   localparam int ADDR_W = $clog2(DEPTH);

   back_state_type state_ff, state_in;

   fe_item_type             item_ff, item_in;
   logic signed [CX_W-1:0]  cx_ff, cx_in, cy_ff, cy_in, xs, ys;
   logic signed [Z_W-1:0]   z_ff, z_in;
   logic [3:0]              step_ff, step_in;
   logic [DPROD_W-1:0]      dprod_ff, dprod_in;
   logic signed [RN_W-1:0]  pa_ff, pa_in, pb_ff, pb_in;
   logic                    flip_ff, flip_in;
   logic [THU_W-1:0]        theta_ff, theta_in;
   logic [DIST_W-1:0]       dist_ff, dist_in, dist_raw;
   logic                    neg_ff, neg_in;
   logic [MAG_W-1:0]        mag_ff, mag_in;
   logic [DEN_W-1:0]        den_ff, den_in;
   logic [Q_W-1:0]          tn_ff, tn_in;
   logic [U_W-1:0]          u_ff, u_in;
   logic [BIN_W-1:0]        abin_ff, abin_in, rbin_ff, rbin_in;
   logic [ADDR_W-1:0]       addr_ff, addr_in;
   logic [ADDR_W-1:0]       clr_ff, clr_in;
   logic [COUNT_W-1:0]      count_ff, count_in;
   logic [TOTAL_W-1:0]      total_ff, total_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;

   // theta folding
   logic signed [TH_W-1:0]  th0, th1, th2;
   logic signed [RN_W-1:0]  rn_raw, rn_f;

   // angle scaling by reciprocal
   logic [APROD_W-1:0]      angle_prod;
   logic [AREM_W-1:0]       angle_rem;

   // bins in use and radius scale
   logic [BIN_W:0]          na, nr;
   logic [BIN_W-1:0]        na_m1, nr_m1;
   logic [MR_W-1:0]         mr;
   logic [Q_W+BIN_W-1:0]    aprod, rprod;

   // vote store
   logic [COUNT_W-1:0]      vote_mem [DEPTH];
   logic [COUNT_W-1:0]      rdata_ff;
   logic                    mem_we;
   logic [ADDR_W-1:0]       mem_waddr;
   logic [COUNT_W-1:0]      mem_wdata;

   // shared divider
   logic                    div_start, div_done;
   logic [NUM_W-1:0]        div_num;
   logic [DEN_W-1:0]        div_den;
   logic [STEP_W-1:0]       div_steps;
   logic [Q_W-1:0]          div_quot;

   hlbh_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .steps (div_steps),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;
   assign sweep_busy = (state_ff == B_INIT);

   // configuration limits
   always_comb begin
      if (angle_bins_used == '0) begin
         na = (BIN_W+1)'(1);
      end else if (int'(angle_bins_used) > MAX_ANGLE_BINS) begin
         na = (BIN_W+1)'(MAX_ANGLE_BINS);
      end else begin
         na = (BIN_W+1)'(angle_bins_used);
      end
      if (radius_bins_used == '0) begin
         nr = (BIN_W+1)'(1);
      end else if (int'(radius_bins_used) > MAX_RADIUS_BINS) begin
         nr = (BIN_W+1)'(MAX_RADIUS_BINS);
      end else begin
         nr = (BIN_W+1)'(radius_bins_used);
      end
      na_m1 = BIN_W'(na - (BIN_W+1)'(1));
      nr_m1 = BIN_W'(nr - (BIN_W+1)'(1));
      mr    = (max_radius == '0) ? MR_W'(1) : max_radius;
   end

   // cordic shifts, floored
   assign xs = cx_ff >>> step_ff;
   assign ys = cy_ff >>> step_ff;

   // angle offset by a quarter turn and folded into 0..pi
   always_comb begin
      th0 = TH_W'(z_ff) + TH_W'(HALF_PI_Q16);
      th1 = (th0 < 0) ? th0 + TH_W'(2 * PI_Q16) : th0;
      th2 = (th1 > TH_W'(PI_Q16)) ? th1 - TH_W'(PI_Q16) : th1;
   end

   // theta * 2^16 / pi: estimate low by at most one, then remainder check
   assign angle_prod = APROD_W'(theta_ff) * APROD_W'(ANGLE_RECIP);
   assign angle_rem  = AREM_W'({theta_ff, 16'b0}) - AREM_W'(tn_ff) * AREM_W'(PI_Q16);

   assign rn_raw   = pa_ff - pb_ff;
   assign rn_f     = flip_ff ? -rn_raw : rn_raw;
   assign dist_raw = dprod_ff[FRAC_BITS +: DIST_W];
   assign aprod    = (Q_W+BIN_W)'(tn_ff) * (Q_W+BIN_W)'(na_m1);
   assign rprod    = (Q_W+BIN_W)'(u_ff) * (Q_W+BIN_W)'(nr_m1);

   // sequencer: next state and datapath updates
   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      z_in         = z_ff;
      step_in      = step_ff;
      dprod_in     = dprod_ff;
      pa_in        = pa_ff;
      pb_in        = pb_ff;
      flip_in      = flip_ff;
      theta_in     = theta_ff;
      dist_in      = dist_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      den_in       = den_ff;
      tn_in        = tn_ff;
      u_in         = u_ff;
      abin_in      = abin_ff;
      rbin_in      = rbin_ff;
      addr_in      = addr_ff;
      clr_in       = clr_ff;
      count_in     = count_ff;
      total_in     = total_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      q_pop        = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = clr_ff;
      mem_wdata    = '0;
      div_start    = 1'b0;
      div_num      = '0;
      div_den      = '0;
      div_steps    = '0;

      unique case (state_ff)
         B_INIT, B_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = B_IDLE;
               if (state_ff == B_CLEAR) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '0;
               end
            end
         end
         B_IDLE: begin
            if (q_not_empty) begin
               q_pop   = 1'b1;
               item_in = q_item;
               rsp_in  = '0;
               rsp_in.total_segments = total_ff;
               case (q_item.op)
                  OP_ADD: begin
                     if (q_item.zero_len) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        cx_in    = CX_W'({q_item.dx, 16'b0});
                        cy_in    = {{(CX_W-CC_W-FRAC_BITS){q_item.dy[CC_W-1]}},
                                    q_item.dy, 16'b0};
                        z_in     = '0;
                        step_in  = '0;
                        state_in = B_CORDIC;
                     end
                  end
                  OP_READ: begin
                     abin_in = BIN_W'(q_item.rd_abin);
                     rbin_in = BIN_W'(q_item.rd_rbin);
                     if ((int'(q_item.rd_abin) < MAX_ANGLE_BINS) &&
                         (int'(q_item.rd_rbin) < MAX_RADIUS_BINS)) begin
                        state_in = B_ADDR;
                     end else begin
                        count_in = '0;
                        state_in = B_FRAC_GO;
                     end
                  end
                  OP_CLEAR: begin
                     clr_in   = '0;
                     total_in = '0;
                     state_in = B_CLEAR;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         B_CORDIC: begin
            if (cy_ff >= 0) begin
               cx_in = cx_ff + ys;
               cy_in = cy_ff - xs;
               z_in  = z_ff + cordic_angle(step_ff);
            end else begin
               cx_in = cx_ff - ys;
               cy_in = cy_ff + xs;
               z_in  = z_ff - cordic_angle(step_ff);
            end
            step_in = step_ff + 4'd1;
            if (step_ff == 4'(CORDIC_STEPS - 1)) begin
               state_in = B_MULT;
            end
         end
         B_MULT: begin
            dprod_in = (cx_ff > 0) ?
                       DPROD_W'(cx_ff[CX_W-2:0]) * DPROD_W'(INV_GAIN_Q16) : '0;
            pa_in    = RN_W'($signed({1'b0, item_ff.dx})) * RN_W'(item_ff.y1c);
            pb_in    = RN_W'(item_ff.x1c) * RN_W'(item_ff.dy);
            flip_in  = (th1 > TH_W'(PI_Q16));
            theta_in = (th2 < 0) ? '0 : th2[THU_W-1:0];
            state_in = B_FOLD;
         end
         B_FOLD: begin
            dist_in  = (dist_raw == '0) ? DIST_W'(1) : dist_raw;
            neg_in   = rn_f[RN_W-1];
            mag_in   = rn_f[RN_W-1] ? MAG_W'(-rn_f) : MAG_W'(rn_f);
            state_in = B_DEN;
         end
         B_DEN: begin
            den_in   = DEN_W'(dist_ff) * DEN_W'({mr, 1'b0});
            state_in = B_ANG_GO;
         end
         B_ANG_GO: begin
            tn_in    = angle_prod[32 +: Q_W];
            state_in = B_ANG_WAIT;
         end
         B_ANG_WAIT: begin
            tn_in    = (angle_rem >= AREM_W'(PI_Q16)) ? tn_ff + Q_W'(1) : tn_ff;
            state_in = B_RAD_GO;
         end
         B_RAD_GO: begin
            if (DEN_W'({mag_ff, 17'b0}) >= den_ff) begin
               // radius clamped at the edge of the range
               u_in     = neg_ff ? '0 : U_W'(Q_ONE);
               state_in = B_BIN;
            end else begin
               div_start = 1'b1;
               div_num   = NUM_W'({mag_ff, 32'b0});
               div_den   = den_ff;
               div_steps = STEP_W'(RADIUS_STEPS);
               state_in  = B_RAD_WAIT;
            end
         end
         B_RAD_WAIT: begin
            if (div_done) begin
               u_in     = neg_ff ? U_W'(HALF_SCALE) - div_quot :
                                   U_W'(HALF_SCALE) + div_quot;
               state_in = B_BIN;
            end
         end
         B_BIN: begin
            abin_in  = aprod[FRAC_BITS +: BIN_W];
            rbin_in  = rprod[FRAC_BITS +: BIN_W];
            state_in = B_ADDR;
         end
         B_ADDR: begin
            addr_in  = ADDR_W'(int'(abin_ff) * MAX_RADIUS_BINS + int'(rbin_ff));
            state_in = B_LOOK;
         end
         B_LOOK: begin
            state_in = B_UPD;
         end
         B_UPD: begin
            if (item_ff.op == OP_ADD) begin
               count_in  = (rdata_ff == COUNT_W'(COUNT_MAX)) ? rdata_ff :
                           rdata_ff + COUNT_W'(1);
               mem_we    = 1'b1;
               mem_waddr = addr_ff;
               mem_wdata = count_in;
               total_in  = (total_ff == TOTAL_W'(TOTAL_MAX)) ? total_ff :
                           total_ff + TOTAL_W'(1);
            end else begin
               count_in = rdata_ff;
            end
            state_in = B_FRAC_GO;
         end
         B_FRAC_GO: begin
            if (total_ff == '0) begin
               rsp_valid_in          = 1'b1;
               rsp_in                = '0;
               rsp_in.angle_bin      = abin_ff[OUT_BIN_W-1:0];
               rsp_in.radius_bin     = rbin_ff[OUT_BIN_W-1:0];
               rsp_in.bin_count      = count_ff;
               state_in              = B_IDLE;
            end else begin
               div_start = 1'b1;
               div_num   = NUM_W'({count_ff, 16'b0});
               div_den   = DEN_W'(total_ff);
               div_steps = STEP_W'(SHARE_STEPS);
               state_in  = B_FRAC_WAIT;
            end
         end
         B_FRAC_WAIT: begin
            if (div_done) begin
               rsp_valid_in          = 1'b1;
               rsp_in.accepted       = (item_ff.op == OP_ADD);
               rsp_in.angle_bin      = abin_ff[OUT_BIN_W-1:0];
               rsp_in.radius_bin     = rbin_ff[OUT_BIN_W-1:0];
               rsp_in.bin_count      = count_ff;
               rsp_in.bin_fraction   = (div_quot > Q_W'(FRAC_MAX)) ?
                                       COUNT_W'(FRAC_MAX) : div_quot[COUNT_W-1:0];
               rsp_in.total_segments = total_ff;
               state_in              = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   // state and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_INIT;
         clr_ff       <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      item_ff  <= item_in;
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      z_ff     <= z_in;
      step_ff  <= step_in;
      dprod_ff <= dprod_in;
      pa_ff    <= pa_in;
      pb_ff    <= pb_in;
      flip_ff  <= flip_in;
      theta_ff <= theta_in;
      dist_ff  <= dist_in;
      neg_ff   <= neg_in;
      mag_ff   <= mag_in;
      den_ff   <= den_in;
      tn_ff    <= tn_in;
      u_ff     <= u_in;
      abin_ff  <= abin_in;
      rbin_ff  <= rbin_in;
      addr_ff  <= addr_in;
      count_ff <= count_in;
      rsp_ff   <= rsp_in;
   end

   // vote store, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         vote_mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= vote_mem[addr_ff];
   end

   a_accept_has_vote: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.accepted) |-> (rsp_ff.bin_count != '0))
      else $error("counted segment reports empty bin");

   a_share_needs_total: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.bin_fraction != '0)) |-> (rsp_ff.total_segments != '0))
      else $error("nonzero share with zero total");

   a_no_result_in_sweep: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_INIT) |-> !rsp_valid_ff)
      else $error("result during power-up sweep");

endmodule

// File: design/hough_line_bin_histogram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hough_line_bin_histogram
// Votes line segments into an angle by radius histogram, reads and clears it.
// ----------------------------------------------------------------------------
// Flow: an add runs the 16-step cordic and two passes through the
//   one-bit-per-cycle divider (one pass when the radius clamps); a read
//   makes one divider pass (none with a zero total), and a zero-length add
//   or unused code is answered straight from idle.
// Queueing: one command at a time in the back; a two-entry queue lets the
//   front take up to three more. A clear sweeps the whole store.
// Reset: a sweep zeroes the store; busy is high until done.
//   Results are strobed for one cycle and the receiver cannot stall.
module hough_line_bin_histogram import hlbh_pkg::*; #(
   parameter int MAX_ANGLE_BINS  = 64,
   parameter int MAX_RADIUS_BINS = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  req_type                req_data,
   output logic                   rsp_valid,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   logic [COORD_BITS-1:0] centre_column_ff;
   logic [COORD_BITS-1:0] centre_row_ff;
   logic [MR_W-1:0]       max_radius_ff;
   logic [NBINS_W-1:0]    angle_bins_ff;
   logic [NBINS_W-1:0]    radius_bins_ff;

   logic        push, q_full, q_not_empty, q_pop, sweep_busy;
   fe_item_type push_item, q_item;

   assign csr_ready = 1'b1;

   // configuration register transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         centre_column_ff <= COORD_BITS'(320);
         centre_row_ff    <= COORD_BITS'(240);
         max_radius_ff    <= MR_W'(320);
         angle_bins_ff    <= NBINS_W'(64);
         radius_bins_ff   <= NBINS_W'(64);
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_CENTRE_COLUMN:    centre_column_ff <= csr_data[COORD_BITS-1:0];
            CSR_CENTRE_ROW:       centre_row_ff    <= csr_data[COORD_BITS-1:0];
            CSR_MAX_RADIUS:       max_radius_ff    <= csr_data[MR_W-1:0];
            CSR_ANGLE_BINS_USED:  angle_bins_ff    <= csr_data[NBINS_W-1:0];
            CSR_RADIUS_BINS_USED: radius_bins_ff   <= csr_data[NBINS_W-1:0];
            default: ;
         endcase
      end
   end

   hlbh_front u_front (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_data      (req_data),
      .centre_column (centre_column_ff),
      .centre_row    (centre_row_ff),
      .hold          (sweep_busy),
      .q_full        (q_full),
      .busy          (busy),
      .push          (push),
      .push_item     (push_item)
   );

   hlbh_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (q_pop),
      .pop_item  (q_item),
      .full      (q_full),
      .not_empty (q_not_empty)
   );

   hlbh_back #(
      .MAX_ANGLE_BINS  (MAX_ANGLE_BINS),
      .MAX_RADIUS_BINS (MAX_RADIUS_BINS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .max_radius       (max_radius_ff),
      .angle_bins_used  (angle_bins_ff),
      .radius_bins_used (radius_bins_ff),
      .q_not_empty      (q_not_empty),
      .q_item           (q_item),
      .q_pop            (q_pop),
      .sweep_busy       (sweep_busy),
      .rsp_valid        (rsp_valid),
      .rsp_data         (rsp_data)
   );

endmodule
